/* design/u8d_pkg.sv */
// Package for the UTF-8 stream decoder: queue entry type, result kinds,
// byte class thresholds and sizes. Used by every module of the block.
package u8d_pkg;

	localparam int DEF_INDEX_BITS = 24;
	localparam int CFG_BITS       = 24;
	localparam int CP_BITS        = 31;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);
	localparam int IN_DATA_BITS   = 8;
	localparam int OUT_DATA_BITS  = 56;
	localparam int APB_ADDR_BITS  = 3;
	localparam int APB_DATA_BITS  = 32;

	localparam logic [7:0] LEAD1_MAX = 8'h7F;
	localparam logic [7:0] LEAD2_MAX = 8'hDF;
	localparam logic [7:0] LEAD3_MAX = 8'hEF;
	localparam logic [7:0] LEAD4_MAX = 8'hF7;
	localparam logic [7:0] LEAD5_MAX = 8'hFB;
	localparam logic [7:0] LEAD6_MAX = 8'hFD;
	localparam logic [7:0] CONT_MASK = 8'h3F;
	localparam logic [7:0] LEAD2_MASK = 8'h1F;

	localparam logic [0:0] REG_FIRST_INDEX = 1'b0;
	localparam logic [0:0] REG_LAST_INDEX  = 1'b1;

	localparam logic [CFG_BITS-1:0] FIRST_INDEX_RST = 24'd1;
	localparam logic [CFG_BITS-1:0] LAST_INDEX_RST  = 24'hFFFFFF;

	typedef enum logic [1:0] {
		KIND_CODE_POINT = 2'd0,
		KIND_BAD_LEAD   = 2'd1,
		KIND_SUMMARY    = 2'd2
	} u8d_kind_t;

	typedef struct packed {
		logic                emit;
		logic                bad_lead;
		logic                eos;
		logic                truncated;
		logic [CP_BITS-1:0]  code_point;
		logic [CFG_BITS-1:0] char_index;
	} u8d_entry_t;

endpackage

/* design/u8d_front.sv */
// Front end of the UTF-8 stream decoder: accepts bytes, tracks the sequence
// state and the character count, filters by index range. Uses u8d_pkg.
module u8d_front import u8d_pkg::*; #(
	parameter int INDEX_BITS = DEF_INDEX_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          byte_value,
	input  logic                end_of_string,
	input  logic [CFG_BITS-1:0] first_index,
	input  logic [CFG_BITS-1:0] last_index,
	output logic                push,
	output u8d_entry_t          entry
);

	localparam int CMP_BITS = (INDEX_BITS > CFG_BITS) ? INDEX_BITS : CFG_BITS;
	localparam logic [INDEX_BITS-1:0] COUNT_MAX = {INDEX_BITS{1'b1}};

	logic [2:0]            pending_q;
	logic [CP_BITS-1:0]    partial_q;
	logic [INDEX_BITS-1:0] count_q;

	logic [2:0]            pending_n;
	logic [CP_BITS-1:0]    partial_n;
	logic [INDEX_BITS-1:0] count_n;
	logic [CMP_BITS-1:0]   count_cmp;
	logic                  in_range;
	logic                  complete;
	logic                  bad;
	logic [CP_BITS-1:0]    cp;

	always_comb begin
		pending_n = pending_q;
		partial_n = partial_q;
		count_n   = count_q;
		complete  = 1'b0;
		bad       = 1'b0;
		cp        = partial_q;
		if (pending_q != 3'd0) begin
			partial_n = {partial_q[CP_BITS-7:0], byte_value[5:0] & CONT_MASK[5:0]};
			pending_n = pending_q - 3'd1;
			complete  = (pending_q == 3'd1);
			cp        = partial_n;
		end else begin
			if (count_q != COUNT_MAX) begin
				count_n = count_q + 1'b1;
			end
			if (byte_value <= LEAD1_MAX) begin
				complete = 1'b1;
				cp       = CP_BITS'(byte_value);
			end else if (byte_value <= LEAD2_MAX) begin
				partial_n = CP_BITS'(byte_value & LEAD2_MASK);
				pending_n = 3'd1;
			end else if (byte_value <= LEAD3_MAX) begin
				partial_n = CP_BITS'(byte_value & 8'h0F);
				pending_n = 3'd2;
			end else if (byte_value <= LEAD4_MAX) begin
				partial_n = CP_BITS'(byte_value & 8'h07);
				pending_n = 3'd3;
			end else if (byte_value <= LEAD5_MAX) begin
				partial_n = CP_BITS'(byte_value & 8'h03);
				pending_n = 3'd4;
			end else if (byte_value <= LEAD6_MAX) begin
				partial_n = CP_BITS'(byte_value & 8'h01);
				pending_n = 3'd5;
			end else begin
				complete = 1'b1;
				bad      = 1'b1;
				cp       = CP_BITS'(byte_value);
			end
		end
	end

	assign count_cmp = CMP_BITS'(count_n);
	assign in_range  = (count_cmp >= CMP_BITS'(first_index)) &&
		(count_cmp <= CMP_BITS'(last_index));

	always_comb begin
		entry.emit       = complete && in_range;
		entry.bad_lead   = bad;
		entry.eos        = end_of_string;
		entry.truncated  = (pending_n != 3'd0);
		entry.code_point = cp;
		entry.char_index = count_cmp[CFG_BITS-1:0];
	end

	assign push = accept && (entry.emit || end_of_string);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			partial_q <= '0;
			count_q   <= '0;
		end else if (accept) begin
			if (end_of_string) begin
				pending_q <= '0;
				partial_q <= '0;
				count_q   <= '0;
			end else begin
				pending_q <= pending_n;
				partial_q <= partial_n;
				count_q   <= count_n;
			end
		end
	end

endmodule

/* design/u8d_queue.sv */
// Short queue between decoder front and back end of the UTF-8 stream
// decoder. Holds u8d_entry_t words. Uses u8d_pkg.
module u8d_queue import u8d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  u8d_entry_t push_entry,
	input  logic       pop,
	output u8d_entry_t head,
	output logic       not_empty,
	output logic       not_full
);

	u8d_entry_t           slot_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic                 do_push;
	logic                 do_pop;

	assign not_empty = (count_q != '0);
	assign not_full  = (count_q != QCNT_BITS'(QUEUE_DEPTH));
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/u8d_back.sv */
// Back end of the UTF-8 stream decoder: turns each queued word into one or
// two results on the output stream. Uses u8d_pkg.
module u8d_back import u8d_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  u8d_entry_t               head,
	input  logic                     head_valid,
	output logic                     pop,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_DATA_BITS-1:0] m_tdata,
	output logic [1:0]               m_tuser,
	output logic                     m_tlast
);

	logic      summary_phase_q;
	logic      show_cp;
	logic      last_piece;
	logic      take;
	u8d_kind_t kind;

	assign show_cp    = head.emit && !summary_phase_q;
	assign last_piece = !(show_cp && head.eos);
	assign m_tvalid   = head_valid;
	assign take       = head_valid && m_tready;
	assign pop        = take && last_piece;

	always_comb begin
		if (show_cp) begin
			kind = head.bad_lead ? KIND_BAD_LEAD : KIND_CODE_POINT;
			m_tdata = {1'b0, head.char_index, head.code_point};
		end else begin
			kind = KIND_SUMMARY;
			m_tdata = {head.truncated, head.char_index, {CP_BITS{1'b0}}};
		end
		m_tuser = kind;
		m_tlast = last_piece;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			summary_phase_q <= 1'b0;
		end else if (take) begin
			summary_phase_q <= !last_piece;
		end
	end

endmodule

/* design/utf8_stream_decoder.sv */
// Top level of the UTF-8 stream decoder: APB registers, front end, queue
// and back end. Uses u8d_pkg, u8d_front, u8d_queue and u8d_back.
//
// Takes one byte per cycle on the input stream while s_tready is high, with tlast
// on the last byte of a string, and decodes leniently: the lead byte sets the
// length and the following bytes add their low six bits. Each completed code
// point whose 1-based index lies in [first_index, last_index] is sent (tuser 0,
// or 1 for lead bytes 0xFE/0xFF), and the last byte of a string adds a summary
// (tuser 2) with the count and a truncated flag. A byte leaves the decoder front
// end in the cycle it is accepted; the output side sends one result per cycle
// while m_tready is high, so a byte that ends a code point and the string gives
// two results, absorbed by a four-word queue between front and back end.
module utf8_stream_decoder import u8d_pkg::*; #(
	parameter int INDEX_BITS = DEF_INDEX_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [IN_DATA_BITS-1:0]  s_tdata,  // byte_value[7:0]
	input  logic                     s_tlast,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_DATA_BITS-1:0] m_tdata,  // code_point[30:0], char_index[54:31],
	                                           // truncated[55]
	output logic [1:0]               m_tuser,  // kind[1:0]
	output logic                     m_tlast
);

	logic [CFG_BITS-1:0] first_index_q;
	logic [CFG_BITS-1:0] last_index_q;
	logic                cfg_write;
	logic                accept;
	logic                push;
	logic                pop;
	logic                not_empty;
	logic                not_full;
	u8d_entry_t          push_entry;
	u8d_entry_t          head;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_index_q <= FIRST_INDEX_RST;
			last_index_q  <= LAST_INDEX_RST;
		end else if (cfg_write) begin
			unique case (paddr[2])
				REG_FIRST_INDEX: first_index_q <= pwdata[CFG_BITS-1:0];
				REG_LAST_INDEX:  last_index_q  <= pwdata[CFG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FIRST_INDEX: prdata = APB_DATA_BITS'(first_index_q);
			REG_LAST_INDEX:  prdata = APB_DATA_BITS'(last_index_q);
			default:         prdata = '0;
		endcase
	end

	assign s_tready = not_full;
	assign accept   = s_tvalid && s_tready;

	u8d_front #(
		.INDEX_BITS(INDEX_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.byte_value   (s_tdata),
		.end_of_string(s_tlast),
		.first_index  (first_index_q),
		.last_index   (last_index_q),
		.push         (push),
		.entry        (push_entry)
	);

	u8d_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.not_full  (not_full)
	);

	u8d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_valid(not_empty),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
